>>> design/isorx_pkg.sv
// Shared types and constants for the transport-layer receive reassembler.
package isorx_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_ADDR_MODE   = 2'd0;
  localparam logic [1:0] REG_EXT_ADDRESS = 2'd1;
  localparam logic [1:0] REG_BUFFER_SIZE = 2'd2;

  localparam logic [11:0] BUFFER_SIZE_RESET = 12'd256;

  // Result kinds.
  localparam logic KIND_SEG = 1'b0;
  localparam logic KIND_FC  = 1'b1;

  // Protocol bytes.
  localparam logic [7:0] PCI_FIRST_FRAME = 8'h10;
  localparam int unsigned FF_FLAG_BIT    = 4;
  localparam logic [7:0] SVC_NEG_RESP    = 8'h7F;
  localparam logic [7:0] NRC_PENDING     = 8'h78;
  localparam logic [7:0] SEQ_FC_RESEND   = 8'h2F;
  localparam logic [7:0] FC_PCI          = 8'h30;
  localparam logic [7:0] FC_BLOCK_SIZE   = 8'h0F;

  localparam logic [8:0] FF_ADJ_NORMAL  = 9'd6;
  localparam logic [8:0] FF_ADJ_EXT     = 9'd5;
  localparam logic [2:0] SEG_LEN_NORMAL = 3'd7;
  localparam logic [2:0] SEG_LEN_EXT    = 3'd6;
  localparam logic [3:0] SF_LEN_NORMAL  = 4'd8;
  localparam logic [3:0] SF_LEN_EXT     = 4'd7;

  typedef struct packed {
    logic        ext_mode;
    logic [7:0]  ext_address;
    logic [11:0] buffer_size;
  } cfg_t;

  // One classified frame: its payload segment and whether a flow control follows.
  typedef struct packed {
    logic [63:0] seg_bytes;
    logic [3:0]  seg_count;
    logic [11:0] seg_offset;
    logic        message_done;
    logic        with_fc;
  } cmd_t;

  typedef enum logic {
    PH_SEG,
    PH_FC
  } phase_t;

endpackage

>>> design/isotp_rx_reassembler.sv
// Top level of the transport-layer receive reassembler.
// An accepted frame's results pass through the command queue and then the output register.
// Frames are taken one per cycle while the command queue is not full; a frame that adds a flow control
// yields two results from the output register, and the command queue absorbs that until it fills.
// Reset (synchronous, active high) returns to idle and loads buffer_size 256.
module isotp_rx_reassembler #(
  parameter int CMD_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [63:0] frame_bytes,
  input  logic        pop,
  output logic        empty,
  output logic        kind,
  output logic [63:0] seg_bytes,
  output logic [3:0]  seg_count,
  output logic [11:0] seg_offset,
  output logic        message_done,
  output logic        last
);
  import isorx_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd, head_cmd;
  logic accept;
  logic front_push;
  logic cmd_pop;
  logic cmd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext_mode    <= 1'b0;
      cfg.ext_address <= 8'd0;
      cfg.buffer_size <= BUFFER_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADDR_MODE:   cfg.ext_mode    <= cfg_data[0];
        REG_EXT_ADDRESS: cfg.ext_address <= cfg_data[7:0];
        REG_BUFFER_SIZE: cfg.buffer_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  isorx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .frame_bytes (frame_bytes),
    .cmd         (front_cmd),
    .cmd_push    (front_push)
  );

  isorx_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_cmd),
    .rd_en   (cmd_pop),
    .rd_data (head_cmd),
    .full    (full),
    .empty   (cmd_empty)
  );

  isorx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (head_cmd),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .seg_bytes    (seg_bytes),
    .seg_count    (seg_count),
    .seg_offset   (seg_offset),
    .message_done (message_done),
    .last         (last)
  );

endmodule

>>> design/isorx_front.sv
// Front end: classifies each received frame, tracks reassembly state, issues commands.
module isorx_front (
  input  logic               clk,
  input  logic               rst,
  input  isorx_pkg::cfg_t    cfg,
  input  logic               accept,
  input  logic [63:0]        frame_bytes,
  output isorx_pkg::cmd_t    cmd,
  output logic               cmd_push
);
  import isorx_pkg::*;

  logic        receiving, receiving_next;
  logic [7:0]  remaining, remaining_next;
  logic [11:0] write_offset, write_offset_next;

  logic [7:0]  fb [8];
  logic        ext;
  logic [7:0]  pci, svc, nrc;
  logic [63:0] tail;
  logic [2:0]  seglen;
  logic        drop;
  logic        is_ff;
  logic [63:0] sf_bytes;
  logic [3:0]  sf_len;
  logic        sf_fit, ff_fit, cf_fit;
  logic [8:0]  ff_diff;
  logic [7:0]  ff_rem, cf_rem;
  logic [12:0] cf_end;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fb[i] = frame_bytes[8*i +: 8];
    end
  end

  assign ext    = cfg.ext_mode;
  assign pci    = ext ? fb[1] : fb[0];
  assign svc    = ext ? fb[2] : fb[1];
  assign nrc    = ext ? fb[4] : fb[3];
  assign tail   = ext ? (frame_bytes >> 16) : (frame_bytes >> 8);
  assign seglen = ext ? SEG_LEN_EXT : SEG_LEN_NORMAL;

  assign drop  = (svc == SVC_NEG_RESP) && (nrc == NRC_PENDING);
  assign is_ff = ext ? fb[1][FF_FLAG_BIT] : (fb[0] == PCI_FIRST_FRAME);

  assign sf_bytes = ext ? (frame_bytes >> 8) : frame_bytes;
  assign sf_len   = ext ? SF_LEN_EXT : SF_LEN_NORMAL;
  assign sf_fit   = {8'd0, sf_len} <= cfg.buffer_size;
  assign ff_fit   = {9'd0, seglen} <= cfg.buffer_size;

  // A length byte below the first frame's own payload means the message is already complete.
  assign ff_diff = {1'b0, svc} - (ext ? FF_ADJ_EXT : FF_ADJ_NORMAL);
  assign ff_rem  = ff_diff[8] ? 8'd0 : ff_diff[7:0];

  assign cf_rem = (remaining > {5'd0, seglen}) ? (remaining - {5'd0, seglen}) : 8'd0;
  assign cf_end = {1'b0, write_offset} + {10'd0, seglen};
  assign cf_fit = cf_end <= {1'b0, cfg.buffer_size};

  always_comb begin
    receiving_next    = receiving;
    remaining_next    = remaining;
    write_offset_next = write_offset;
    cmd               = '0;
    cmd_push          = 1'b0;
    if (!receiving) begin
      if (!drop) begin
        cmd_push = 1'b1;
        if (!is_ff) begin
          cmd.seg_bytes     = sf_fit ? sf_bytes : 64'd0;
          cmd.seg_count     = sf_fit ? sf_len : 4'd0;
          cmd.message_done  = 1'b1;
          write_offset_next = 12'd0;
        end else begin
          cmd.seg_bytes     = ff_fit ? tail : 64'd0;
          cmd.seg_count     = ff_fit ? {1'b0, seglen} : 4'd0;
          cmd.message_done  = (ff_rem == 8'd0);
          cmd.with_fc       = 1'b1;
          remaining_next    = ff_rem;
          write_offset_next = ff_fit ? {9'd0, seglen} : 12'd0;
          receiving_next    = (ff_rem != 8'd0);
        end
      end
    end else begin
      cmd_push         = 1'b1;
      cmd.seg_bytes    = cf_fit ? tail : 64'd0;
      cmd.seg_count    = cf_fit ? {1'b0, seglen} : 4'd0;
      cmd.seg_offset   = write_offset;
      cmd.message_done = (cf_rem == 8'd0);
      cmd.with_fc      = (pci == SEQ_FC_RESEND);
      remaining_next   = cf_rem;
      if (cf_fit) begin
        write_offset_next = cf_end[11:0];
      end
      receiving_next = (cf_rem != 8'd0);
    end
    cmd_push = cmd_push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving    <= 1'b0;
      remaining    <= 8'd0;
      write_offset <= 12'd0;
    end else if (accept) begin
      receiving    <= receiving_next;
      remaining    <= remaining_next;
      write_offset <= write_offset_next;
    end
  end

endmodule

>>> design/isorx_cmd_fifo.sv
// Short command queue between the frame classifier and the result sequencer.
module isorx_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  isorx_pkg::cmd_t  wr_data,
  input  logic             rd_en,
  output isorx_pkg::cmd_t  rd_data,
  output logic             full,
  output logic             empty
);
  import isorx_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> design/isorx_back.sv
// Back end: expands each command into its segment and optional flow control result.
module isorx_back (
  input  logic               clk,
  input  logic               rst,
  input  isorx_pkg::cfg_t    cfg,
  input  isorx_pkg::cmd_t    cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output logic               kind,
  output logic [63:0]        seg_bytes,
  output logic [3:0]         seg_count,
  output logic [11:0]        seg_offset,
  output logic               message_done,
  output logic               last
);
  import isorx_pkg::*;

  phase_t      phase, phase_next;
  logic        out_valid;
  logic        load;
  logic [63:0] fc_bytes;

  logic        kind_next;
  logic [63:0] bytes_next;
  logic [3:0]  count_next;
  logic [11:0] offset_next;
  logic        done_next;
  logic        last_next;

  assign fc_bytes = cfg.ext_mode ? {40'd0, FC_BLOCK_SIZE, FC_PCI, cfg.ext_address}
                                 : {48'd0, FC_BLOCK_SIZE, FC_PCI};

  // The output register refills in the same cycle that its result is transferred.
  assign load  = (!out_valid || pop) && !cmd_empty;
  assign empty = !out_valid;

  always_comb begin
    phase_next  = phase;
    cmd_pop     = 1'b0;
    kind_next   = KIND_SEG;
    bytes_next  = cmd.seg_bytes;
    count_next  = cmd.seg_count;
    offset_next = cmd.seg_offset;
    done_next   = cmd.message_done;
    last_next   = !cmd.with_fc;
    unique case (phase)
      PH_SEG: begin
        if (load) begin
          if (cmd.with_fc) begin
            phase_next = PH_FC;
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      PH_FC: begin
        kind_next   = KIND_FC;
        bytes_next  = fc_bytes;
        count_next  = 4'd0;
        offset_next = 12'd0;
        done_next   = 1'b0;
        last_next   = 1'b1;
        if (load) begin
          cmd_pop    = 1'b1;
          phase_next = PH_SEG;
        end
      end
      default: begin
        phase_next = PH_SEG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEG;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= kind_next;
      seg_bytes    <= bytes_next;
      seg_count    <= count_next;
      seg_offset   <= offset_next;
      message_done <= done_next;
      last         <= last_next;
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the transport-layer receive reassembler.
`timescale 1ns / 1ps

module tb_top;
  import isorx_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_FRAMES = 80;

  typedef struct {
    logic        kind;
    logic [63:0] data;
    logic [3:0]  count;
    logic [11:0] offset;
    logic        done;
    logic        last;
  } rx_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ADDR_MODE;
  logic [11:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] frame_bytes = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic        kind;
  logic [63:0] seg_bytes;
  logic [3:0]  seg_count;
  logic [11:0] seg_offset;
  logic        message_done;
  logic        last;

  isotp_rx_reassembler i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .frame_bytes  (frame_bytes),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .seg_bytes    (seg_bytes),
    .seg_count    (seg_count),
    .seg_offset   (seg_offset),
    .message_done (message_done),
    .last         (last)
  );

  // Predictor copy of the registers and of the reassembly state.
  logic        m_ext = 1'b0;
  logic [7:0]  m_ext_addr = 8'd0;
  logic [11:0] m_buf_size = BUFFER_SIZE_RESET;
  logic        rx_active = 1'b0;
  logic [7:0]  rx_remaining = 8'd0;
  logic [11:0] rx_offset = 12'd0;

  rx_result_t pending_results[$];
  int errors = 0;
  int frames_answered = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  int rx_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[isotp_rx_reassembler] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] frame_byte(input logic [63:0] f, input int idx);
    return f[8*idx +: 8];
  endfunction

  // A segment that would run past the buffer is reported empty and keeps its offset.
  function automatic bit add_segment(input logic [63:0] data, input int len, input int off,
                                     input logic done, input logic is_last);
    rx_result_t r;
    bit fits;
    fits = (off + len) <= int'(m_buf_size);
    r.kind   = KIND_SEG;
    r.data   = fits ? data : 64'd0;
    r.count  = fits ? 4'(len) : 4'd0;
    r.offset = 12'(off);
    r.done   = done;
    r.last   = is_last;
    pending_results.push_back(r);
    return fits;
  endfunction

  function automatic void add_flow_control();
    rx_result_t r;
    r.kind   = KIND_FC;
    r.data   = m_ext ? {40'd0, FC_BLOCK_SIZE, FC_PCI, m_ext_addr} : {48'd0, FC_BLOCK_SIZE, FC_PCI};
    r.count  = 4'd0;
    r.offset = 12'd0;
    r.done   = 1'b0;
    r.last   = 1'b1;
    pending_results.push_back(r);
  endfunction

  // Works out the results of one accepted frame; returns how many there are.
  function automatic int reassemble_frame(input logic [63:0] f);
    int pci;
    int seg_len;
    int rem;
    logic fc_next;
    pci = m_ext ? 1 : 0;
    seg_len = m_ext ? 6 : 7;
    if (!rx_active) begin
      if (frame_byte(f, pci + 1) == SVC_NEG_RESP && frame_byte(f, pci + 3) == NRC_PENDING)
        return 0;
      if (m_ext ? !f[8 + FF_FLAG_BIT] : (frame_byte(f, 0) != PCI_FIRST_FRAME)) begin
        void'(add_segment(m_ext ? (f >> 8) : f, m_ext ? 7 : 8, 0, 1'b1, 1'b1));
        rx_offset = 12'd0;
        return 1;
      end
      rem = int'(frame_byte(f, pci + 1)) - (m_ext ? 5 : 6);
      if (rem < 0) rem = 0;
      rx_remaining = 8'(rem);
      rx_offset = 12'd0;
      if (add_segment(f >> (8 * (pci + 1)), seg_len, 0, rx_remaining == 0, 1'b0))
        rx_offset = 12'(seg_len);
      add_flow_control();
      rx_active = (rx_remaining != 0);
      return 2;
    end
    // While receiving, every frame counts as a consecutive frame.
    if (rx_remaining > seg_len) rx_remaining = rx_remaining - 8'(seg_len);
    else rx_remaining = 8'd0;
    fc_next = (frame_byte(f, pci) == SEQ_FC_RESEND);
    if (add_segment(f >> (8 * (pci + 1)), seg_len, int'(rx_offset), rx_remaining == 0,
                    !fc_next))
      rx_offset = rx_offset + 12'(seg_len);
    if (fc_next) add_flow_control();
    if (rx_remaining == 0) rx_active = 1'b0;
    return fc_next ? 2 : 1;
  endfunction

  task automatic send_frame(input logic [63:0] f);
    if (!steady && $urandom_range(99) < 6) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    frame_bytes <= f;
    do @(posedge clk); while (full);
    if (reassemble_frame(f) > 0) frames_answered++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ADDR_MODE:   m_ext = value[0];
      REG_EXT_ADDRESS: m_ext_addr = value[7:0];
      REG_BUFFER_SIZE: m_buf_size = value;
      default: ;
    endcase
  endtask

  // Builds a frame with the given PCI byte in the position of the current mode.
  function automatic logic [63:0] with_pci(input logic [7:0] pci_byte);
    logic [63:0] f;
    f = {$urandom, $urandom};
    f[8 * (m_ext ? 1 : 0) +: 8] = pci_byte;
    return f;
  endfunction

  function automatic logic [63:0] first_frame(input logic [7:0] len);
    logic [63:0] f;
    f = with_pci(m_ext ? (8'($urandom) | PCI_FIRST_FRAME) : PCI_FIRST_FRAME);
    f[8 * (m_ext ? 2 : 1) +: 8] = len;
    return f;
  endfunction

  function automatic logic [63:0] pending_reply();
    logic [63:0] f;
    int pci;
    pci = m_ext ? 1 : 0;
    f = {$urandom, $urandom};
    f[8 * (pci + 1) +: 8] = SVC_NEG_RESP;
    f[8 * (pci + 3) +: 8] = NRC_PENDING;
    return f;
  endfunction

  task automatic send_random_message();
    int seg_len;
    int rem;
    int n_cf;
    int pick;
    int len;
    seg_len = m_ext ? 6 : 7;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 255);
      send_frame(first_frame(8'(len)));
      rem = len - (m_ext ? 5 : 6);
      if (rem < 0) rem = 0;
      n_cf = (rem + seg_len - 1) / seg_len;
      // Now and then the message is broken off early.
      if ($urandom_range(9) == 0) n_cf = $urandom_range(0, n_cf);
      for (int i = 1; i <= n_cf; i++) send_frame(with_pci(8'h20 | 8'(i & 15)));
    end else if (pick < 82) begin
      send_frame(with_pci(8'($urandom_range(0, 7))));
    end else if (pick < 90) begin
      send_frame(pending_reply());
    end else begin
      send_frame({$urandom, $urandom});
    end
  endtask

  // Receiver: random pop idling, plus a long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(99) < 6) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic check_result();
    rx_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d seg_bytes %h", kind, seg_bytes);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, kind);
      errors++;
    end
    if (seg_bytes !== want.data) begin
      $error("seg_bytes: expected %h, actual %h", want.data, seg_bytes);
      errors++;
    end
    if (seg_count !== want.count) begin
      $error("seg_count: expected %0d, actual %0d", want.count, seg_count);
      errors++;
    end
    if (seg_offset !== want.offset) begin
      $error("seg_offset: expected %0d, actual %0d", want.offset, seg_offset);
      errors++;
    end
    if (message_done !== want.done) begin
      $error("message_done: expected %0d, actual %0d", want.done, message_done);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, last);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_result();
  end

  task automatic test_normal_frames();
    send_frame(64'h0);
    send_frame({64{1'b1}});
    send_frame(pending_reply());
    // A length shorter than the first segment completes the message at once.
    send_frame(first_frame(8'h03));
    send_frame(first_frame(8'd20));
    send_frame(with_pci(8'h21));
    send_frame(with_pci(SEQ_FC_RESEND));
    wait_drained();
  endtask

  task automatic test_extended_frames();
    write_reg(REG_ADDR_MODE, 12'd1);
    write_reg(REG_EXT_ADDRESS, 12'hFF);
    send_frame(with_pci(8'h05));
    send_frame(pending_reply());
    send_frame(first_frame(8'd11));
    send_frame(with_pci(8'h21));
    wait_drained();
    write_reg(REG_EXT_ADDRESS, 12'h00);
    send_frame(first_frame(8'd12));
    send_frame(with_pci(SEQ_FC_RESEND));
    wait_drained();
  endtask

  task automatic test_buffer_limit();
    write_reg(REG_ADDR_MODE, 12'd0);
    write_reg(REG_BUFFER_SIZE, 12'd0);
    send_frame(with_pci(8'h02));
    wait_drained();
    write_reg(REG_BUFFER_SIZE, 12'd10);
    send_frame(first_frame(8'd30));
    send_frame(with_pci(8'h21));
    send_frame(with_pci(8'h22));
    wait_drained();
    // The dropped segments did not advance the offset.
    write_reg(REG_BUFFER_SIZE, 12'd4095);
    send_frame(with_pci(8'h23));
    send_frame(with_pci(8'h24));
    wait_drained();
  endtask

  task automatic test_mode_switch();
    write_reg(REG_BUFFER_SIZE, 12'd256);
    send_frame(first_frame(8'd30));
    send_frame(with_pci(8'h21));
    wait_drained();
    write_reg(REG_ADDR_MODE, 12'd1);
    write_reg(REG_EXT_ADDRESS, 12'h5A);
    send_frame(with_pci(8'h22));
    send_frame(with_pci(SEQ_FC_RESEND));
    send_frame(with_pci(8'h24));
    wait_drained();
    write_reg(REG_ADDR_MODE, 12'd0);
  endtask

  task automatic test_backpressure();
    rx_hold_req = 150;
    send_frame(first_frame(8'd200));
    for (int i = 1; i <= 28; i++) send_frame(with_pci(8'h20 | 8'(i & 15)));
    wait_drained();
  endtask

  task automatic test_random_messages();
    int target;
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      steady = (phase == 0);
      write_reg(REG_ADDR_MODE, 12'($urandom_range(1)));
      case (phase)
        0: write_reg(REG_EXT_ADDRESS, 12'hFF);
        1: write_reg(REG_EXT_ADDRESS, 12'h00);
        default: write_reg(REG_EXT_ADDRESS, 12'($urandom_range(255)));
      endcase
      case (phase)
        0: write_reg(REG_BUFFER_SIZE, 12'd4095);
        1: write_reg(REG_BUFFER_SIZE, 12'($urandom_range(0, 300)));
        2: write_reg(REG_BUFFER_SIZE, BUFFER_SIZE_RESET);
        3: write_reg(REG_BUFFER_SIZE, 12'($urandom_range(0, 4095)));
        default: write_reg(REG_BUFFER_SIZE, 12'($urandom_range(8, 120)));
      endcase
      target = frames_answered + PHASE_FRAMES;
      while (frames_answered < target) send_random_message();
    end
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_normal_frames();
    test_extended_frames();
    test_buffer_limit();
    test_mode_switch();
    test_backpressure();
    test_random_messages();
    if (errors == 0) begin
      $display("[isotp_rx_reassembler] OK");
    end else begin
      $display("[isotp_rx_reassembler] ERROR");
    end
    $finish;
  end

endmodule
